// ===== hdl/fortran_record_endian_swapper_assert.svh =====
// ----------------------------------------------------------------------------
// fortran_record_endian_swapper_assert.svh
// assertion macros used by the record swapper top level
// ----------------------------------------------------------------------------
`ifndef FORTRAN_RECORD_ENDIAN_SWAPPER_ASSERT_SVH
`define FORTRAN_RECORD_ENDIAN_SWAPPER_ASSERT_SVH

// same-cycle implication
`define FRE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fre: assertion failed");

// next-cycle implication
`define FRE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fre: assertion failed");

`endif

// ===== hdl/fre_pkg.sv =====
// ----------------------------------------------------------------------------
// fre_pkg
// types, codes and helpers for the record endian swapper
// ----------------------------------------------------------------------------
package fre_pkg;

  localparam int FIFO_DEPTH = 2;

  localparam logic [3:0] REAL_BYTES_RESET = 4'd8;
  localparam logic [3:0] SINGLE_BYTES     = 4'd4;
  localparam logic [3:0] DOUBLE_BYTES     = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_DAY,
    PH_SECS,
    PH_TRL1,
    PH_HDR2,
    PH_REALS,
    PH_TRL2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_FIRST_TRL,
    KIND_DATA_TRL
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FIRST_MISMATCH,
    ST_DATA_MISMATCH
  } status_t;

  typedef struct packed {
    logic [63:0] item;
    logic        is8;
    kind_t       kind;
    logic [31:0] expect_q;
    logic        by8;
  } entry_t;

  // signed count divided by 4 or 8, truncated toward zero
  function automatic logic [31:0] sdiv(input logic [31:0] v, input logic by8);
    logic [31:0] mag;
    logic [31:0] q;
    mag = v[31] ? (32'd0 - v) : v;
    q   = by8 ? (mag >> 3) : (mag >> 2);
    return v[31] ? (32'd0 - q) : q;
  endfunction

endpackage

// ===== hdl/fre_fifo.sv =====
// ----------------------------------------------------------------------------
// fre_fifo
// short request queue between the record parser and the output stage
// ----------------------------------------------------------------------------
module fre_fifo #(
  parameter int DEPTH = fre_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fre_pkg::entry_t push_data,
  input  logic            pop,
  output fre_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  fre_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/fre_front.sv =====
// ----------------------------------------------------------------------------
// fre_front
// byte intake: assembles items and tracks the record layout
// ----------------------------------------------------------------------------
module fre_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic [3:0]      real_bytes,
  input  logic            q_full,
  output logic            q_push,
  output fre_pkg::entry_t q_data
);

  fre_pkg::phase_t phase;
  fre_pkg::phase_t phase_next;
  logic [2:0]      byte_pos;
  logic [63:0]     item_buf;
  logic [31:0]     first_q;
  logic [31:0]     expect_q;
  logic [31:0]     remaining;

  logic        accept;
  logic        is4;
  logic        size8;
  logic [2:0]  pos_inc;
  logic [63:0] buf_new;
  logic        complete;
  logic [31:0] cnt;
  logic        div_by8;
  logic [31:0] quot;
  logic        quot_pos;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is4      = (real_bytes == fre_pkg::SINGLE_BYTES);
  assign size8    = (phase == fre_pkg::PH_REALS) && !is4;
  assign pos_inc  = byte_pos + 3'd1;
  assign buf_new  = {item_buf[55:0], in_byte};
  // 8-byte items finish on wrap, 4-byte ones at the fourth byte
  assign complete = (pos_inc == 3'd0) || (!size8 && pos_inc >= 3'd4);
  assign cnt      = buf_new[31:0];
  assign div_by8  = (phase == fre_pkg::PH_HDR2) && !is4;
  assign quot     = fre_pkg::sdiv(cnt, div_by8);
  assign quot_pos = !cnt[31] && (quot != 32'd0);

  always_comb begin
    phase_next = phase;
    if (accept && complete) begin
      case (phase)
        fre_pkg::PH_HDR1:  phase_next = fre_pkg::PH_DAY;
        fre_pkg::PH_DAY:   phase_next = fre_pkg::PH_SECS;
        fre_pkg::PH_SECS:  phase_next = fre_pkg::PH_TRL1;
        fre_pkg::PH_TRL1:  phase_next = fre_pkg::PH_HDR2;
        fre_pkg::PH_HDR2:  phase_next = quot_pos ? fre_pkg::PH_REALS : fre_pkg::PH_TRL2;
        fre_pkg::PH_REALS: phase_next = (remaining == 32'd1) ? fre_pkg::PH_TRL2
                                                             : fre_pkg::PH_REALS;
        fre_pkg::PH_TRL2:  phase_next = fre_pkg::PH_HDR1;
        default:           phase_next = fre_pkg::PH_HDR1;
      endcase
    end
  end

  always_comb begin
    q_push          = accept && complete;
    q_data.item     = size8 ? buf_new : {32'd0, buf_new[31:0]};
    q_data.is8      = size8;
    q_data.expect_q = expect_q;
    q_data.by8      = !is4;
    case (phase)
      fre_pkg::PH_TRL1: begin
        q_data.kind     = fre_pkg::KIND_FIRST_TRL;
        q_data.expect_q = first_q;
        q_data.by8      = 1'b0;
      end
      fre_pkg::PH_TRL2: begin
        q_data.kind = fre_pkg::KIND_DATA_TRL;
      end
      default: begin
        q_data.kind = fre_pkg::KIND_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= fre_pkg::PH_HDR1;
      byte_pos  <= '0;
      item_buf  <= '0;
      first_q   <= '0;
      expect_q  <= '0;
      remaining <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (complete) begin
          byte_pos <= '0;
          item_buf <= '0;
          case (phase)
            fre_pkg::PH_HDR1: begin
              first_q <= quot;
            end
            fre_pkg::PH_HDR2: begin
              expect_q  <= quot;
              remaining <= quot_pos ? quot : 32'd0;
            end
            fre_pkg::PH_REALS: begin
              remaining <= remaining - 32'd1;
            end
            default: begin
            end
          endcase
        end else begin
          byte_pos <= pos_inc;
          item_buf <= buf_new;
        end
      end
    end
  end

endmodule

// ===== hdl/fre_back.sv =====
// ----------------------------------------------------------------------------
// fre_back
// output stage: checks trailer counts and holds the result register
// ----------------------------------------------------------------------------
module fre_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  fre_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     item_value,
  output logic [3:0]      item_bytes,
  output logic            dataset_done,
  output logic [1:0]      status,
  output logic            halted
);

  logic             load;
  logic [31:0]      chk_q;
  logic             mismatch;
  fre_pkg::status_t status_new;

  assign chk_q    = fre_pkg::sdiv(q_head.item[31:0], q_head.by8);
  assign mismatch = (q_head.kind != fre_pkg::KIND_PLAIN) && (chk_q != q_head.expect_q);
  // once halted the queue drains without producing results
  assign q_pop    = !q_empty && (halted || !out_valid || !out_stall);
  assign load     = q_pop && !halted;

  always_comb begin
    status_new = fre_pkg::ST_OK;
    if (mismatch) begin
      case (q_head.kind)
        fre_pkg::KIND_FIRST_TRL: status_new = fre_pkg::ST_FIRST_MISMATCH;
        fre_pkg::KIND_DATA_TRL:  status_new = fre_pkg::ST_DATA_MISMATCH;
        default:                 status_new = fre_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      halted    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && mismatch) begin
        halted <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_value   <= q_head.item;
      item_bytes   <= q_head.is8 ? fre_pkg::DOUBLE_BYTES : fre_pkg::SINGLE_BYTES;
      dataset_done <= (q_head.kind == fre_pkg::KIND_DATA_TRL) && !mismatch;
      status       <= status_new;
    end
  end

endmodule

// ===== hdl/fortran_record_endian_swapper.sv =====
// ----------------------------------------------------------------------------
// fortran_record_endian_swapper
// Byte swapper for an unformatted restart stream. Takes one byte per cycle
// while the queue has room, follows the record layout (header, day, seconds,
// trailer, data header, reals, data trailer) and returns each finished item
// with its bytes reversed. The sustained rate is one byte per cycle, set by
// the byte assembly register in the front end; each result passes through
// the request queue and then the output register. A queue of QUEUE_DEPTH
// entries lets intake continue while the output is stalled. A trailer count
// mismatch is reported with an error status, after which no further results
// are produced until reset; input bytes are still taken and dropped.
// ----------------------------------------------------------------------------
module fortran_record_endian_swapper #(
  parameter int QUEUE_DEPTH = fre_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] item_value,
  output logic [3:0]  item_bytes,
  output logic        dataset_done,
  output logic [1:0]  status
);

  logic [3:0]      real_bytes;
  logic            q_push;
  fre_pkg::entry_t q_data;
  logic            q_pop;
  fre_pkg::entry_t q_head;
  logic            q_full;
  logic            q_empty;
  logic            halted;

  always_ff @(posedge clk) begin
    if (rst) begin
      real_bytes <= fre_pkg::REAL_BYTES_RESET;
    end else if (cfg_wen) begin
      real_bytes <= cfg_wdata;
    end
  end

  fre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .real_bytes (real_bytes),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  fre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  fre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_value   (item_value),
    .item_bytes   (item_bytes),
    .dataset_done (dataset_done),
    .status       (status),
    .halted       (halted)
  );

`include "fortran_record_endian_swapper_assert.svh"

  `FRE_ASSERT_IMPLY(a_item_size, clk, rst, out_valid, item_bytes == fre_pkg::SINGLE_BYTES || item_bytes == fre_pkg::DOUBLE_BYTES)
  `FRE_ASSERT_IMPLY(a_upper_zero, clk, rst, out_valid && item_bytes == fre_pkg::SINGLE_BYTES, item_value[63:32] == 32'd0)
  `FRE_ASSERT_IMPLY(a_error_not_done, clk, rst, out_valid && status != fre_pkg::ST_OK, !dataset_done)
  `FRE_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted)

endmodule
